// ===== src/tccw_pkg.sv =====
// Shared types, constants and control structs for the text console cell writer
package tccw_pkg;

  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  localparam int FUNC_W       = 2;
  localparam int CHAR_W       = 8;
  localparam int COLOR_W      = 8;
  localparam int COLUMN_IN_W  = 7;
  localparam int ROW_IN_W     = 5;
  localparam int CURSOR_POS_W = 11;
  localparam int CELL_W       = 16;

  localparam int TAB_SPACES = 4;
  localparam int REP_W      = $clog2(TAB_SPACES);

  localparam logic [CHAR_W-1:0]  CH_TAB      = 8'h09;
  localparam logic [CHAR_W-1:0]  CH_NEWLINE  = 8'h0A;
  localparam logic [CHAR_W-1:0]  CH_SPACE    = 8'h20;
  localparam logic [COLOR_W-1:0] RESET_COLOR = 8'h07;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUT   = 2'd0,
    FUNC_ERASE = 2'd1,
    FUNC_WRITE = 2'd2,
    FUNC_READ  = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_OP,
    ST_SCROLL,
    ST_DONE,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic [FUNC_W-1:0]      func;
    logic [CHAR_W-1:0]      char_code;
    logic [COLOR_W-1:0]     cell_color;
    logic [COLUMN_IN_W-1:0] column_in;
    logic [ROW_IN_W-1:0]    row_in;
  } in_t;

  typedef struct packed {
    logic [CURSOR_POS_W-1:0] cursor_pos;
    logic [CELL_W-1:0]       cell_data;
  } out_t;

  typedef struct packed {
    logic accept;
    logic clear_step;
    logic put_step;
    logic scroll_start;
    logic scroll_step;
    logic erase;
    logic direct_wr;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    func_e func;
    logic  pend;
    logic  cnt_last;
    logic  rep_last;
  } sts_t;

endpackage

// ===== src/tccw_ctrl.sv =====
// Controller state machine for the text console cell writer
module tccw_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  tccw_pkg::sts_t   sts_i,
  output tccw_pkg::cmd_t   cmd_o
);

  tccw_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tccw_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tccw_pkg::ST_CLEAR: begin
        if (sts_i.cnt_last) state_d = tccw_pkg::ST_IDLE;
      end
      tccw_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = tccw_pkg::ST_OP;
      end
      tccw_pkg::ST_OP: begin
        unique case (sts_i.func)
          tccw_pkg::FUNC_PUT: begin
            if (sts_i.pend) begin
              state_d = tccw_pkg::ST_SCROLL;
            end else if (sts_i.rep_last) begin
              state_d = tccw_pkg::ST_DONE;
            end
          end
          default: state_d = tccw_pkg::ST_DONE;
        endcase
      end
      tccw_pkg::ST_SCROLL: begin
        if (sts_i.cnt_last) state_d = tccw_pkg::ST_OP;
      end
      tccw_pkg::ST_DONE: state_d = tccw_pkg::ST_RESP;
      tccw_pkg::ST_RESP: begin
        if (out_ready_i) state_d = tccw_pkg::ST_IDLE;
      end
      default: state_d = tccw_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      tccw_pkg::ST_CLEAR: cmd_o.clear_step = 1'b1;
      tccw_pkg::ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      tccw_pkg::ST_OP: begin
        unique case (sts_i.func)
          tccw_pkg::FUNC_PUT: begin
            cmd_o.scroll_start = sts_i.pend;
            cmd_o.put_step     = !sts_i.pend;
          end
          tccw_pkg::FUNC_ERASE: cmd_o.erase     = 1'b1;
          tccw_pkg::FUNC_WRITE: cmd_o.direct_wr = 1'b1;
          default: ;
        endcase
      end
      tccw_pkg::ST_SCROLL: cmd_o.scroll_step = 1'b1;
      tccw_pkg::ST_DONE:   cmd_o.load_out    = 1'b1;
      tccw_pkg::ST_RESP:   out_valid_o       = 1'b1;
      default: ;
    endcase
  end

endmodule

// ===== src/tccw_datapath.sv =====
// Datapath: screen memory, cursor, write stage and result register
module tccw_datapath #(
  parameter int COLUMNS = tccw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tccw_pkg::DEF_ROWS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  tccw_pkg::in_t                in_data_i,
  input  logic                         cfg_we_i,
  input  logic [tccw_pkg::COLOR_W-1:0] cfg_wdata_i,
  input  tccw_pkg::cmd_t               cmd_i,
  output tccw_pkg::sts_t               sts_o,
  output tccw_pkg::out_t               out_data_o
);

  localparam int TOTAL      = COLUMNS * ROWS;
  localparam int ADDR_W     = $clog2(TOTAL);
  localparam int ROW_W      = $clog2(ROWS + 1);
  localparam int COL_W      = $clog2(COLUMNS);
  localparam int POS_W      = $clog2(TOTAL + 1);
  localparam int BLANK_BASE = (ROWS - 1) * COLUMNS;
  localparam int CELL_W     = tccw_pkg::CELL_W;

  logic [CELL_W-1:0] mem [TOTAL];

  tccw_pkg::in_t                item_q, item_d;
  logic [ROW_W-1:0]             row_q, row_d;
  logic [COL_W-1:0]             col_q, col_d;
  logic                         pend_q, pend_d;
  logic [tccw_pkg::COLOR_W-1:0] color_q;
  logic [tccw_pkg::REP_W-1:0]   rep_q, rep_d;
  logic [ADDR_W-1:0]            cnt_q, cnt_d;
  logic                         we_q, we_d;
  logic [ADDR_W-1:0]            wa_q, wa_d;
  logic [CELL_W-1:0]            wd_q, wd_d;
  logic                         wcopy_q, wcopy_d;
  logic [CELL_W-1:0]            rd_q;
  tccw_pkg::out_t               out_q;

  logic              item_ok, cur_ok, cnt_last, wrap_full;
  logic [ADDR_W-1:0] item_addr, cur_addr;
  logic [COL_W-1:0]  col_m1, cur_col;
  logic [ROW_W-1:0]  row_inc, row_wrap;
  logic [POS_W-1:0]  pos;
  logic [ADDR_W:0]   scroll_src, ra;
  logic              re;

  assign item_ok   = (int'(item_q.column_in) < COLUMNS) && (int'(item_q.row_in) < ROWS);
  assign item_addr = ADDR_W'(item_q.row_in) * ADDR_W'(COLUMNS) + ADDR_W'(item_q.column_in);
  assign col_m1    = col_q - 1'b1;
  assign cur_col   = cmd_i.erase ? col_m1 : col_q;
  assign cur_addr  = ADDR_W'(row_q) * ADDR_W'(COLUMNS) + ADDR_W'(cur_col);
  assign cur_ok    = int'(row_q) < ROWS;
  assign pos       = POS_W'(row_q) * POS_W'(COLUMNS) + POS_W'(col_q);
  assign row_inc   = row_q + 1'b1;
  assign wrap_full = int'(row_inc) >= ROWS;
  assign row_wrap  = wrap_full ? ROW_W'(ROWS) : row_inc;
  assign cnt_last  = cnt_q == ADDR_W'(TOTAL - 1);

  assign scroll_src = (ADDR_W + 1)'(cnt_q) + (ADDR_W + 1)'(COLUMNS);
  assign ra         = cmd_i.scroll_step ? scroll_src : {1'b0, item_addr};
  assign re         = int'(ra) < TOTAL;

  always_comb begin
    item_d  = item_q;
    row_d   = row_q;
    col_d   = col_q;
    pend_d  = pend_q;
    rep_d   = rep_q;
    cnt_d   = cnt_q;
    we_d    = 1'b0;
    wa_d    = cur_addr;
    wd_d    = {color_q, tccw_pkg::CH_SPACE};
    wcopy_d = 1'b0;

    if (cmd_i.accept) begin
      item_d = in_data_i;
      rep_d  = '0;
      if (tccw_pkg::func_e'(in_data_i.func) == tccw_pkg::FUNC_PUT &&
          in_data_i.char_code == tccw_pkg::CH_TAB) begin
        item_d.char_code = tccw_pkg::CH_SPACE;
        rep_d            = tccw_pkg::REP_W'(tccw_pkg::TAB_SPACES - 1);
      end
    end

    if (cmd_i.clear_step) begin
      we_d  = 1'b1;
      wa_d  = cnt_q;
      wd_d  = {tccw_pkg::RESET_COLOR, tccw_pkg::CH_SPACE};
      cnt_d = cnt_q + 1'b1;
    end

    if (cmd_i.scroll_start) begin
      cnt_d = ADDR_W'(COLUMNS);
    end

    if (cmd_i.scroll_step) begin
      we_d    = 1'b1;
      wa_d    = cnt_q;
      wcopy_d = int'(cnt_q) < BLANK_BASE;
      cnt_d   = cnt_q + 1'b1;
      if (cnt_last) begin
        pend_d = 1'b0;
        if (row_q != '0) row_d = row_q - 1'b1;
      end
    end

    if (cmd_i.put_step) begin
      rep_d = rep_q - 1'b1;
      if (item_q.char_code == tccw_pkg::CH_NEWLINE) begin
        col_d  = '0;
        row_d  = row_wrap;
        pend_d = wrap_full;
      end else begin
        we_d = cur_ok;
        wd_d = {color_q, item_q.char_code};
        if (col_q == COL_W'(COLUMNS - 1)) begin
          col_d  = '0;
          row_d  = row_wrap;
          pend_d = wrap_full;
        end else begin
          col_d = col_q + 1'b1;
        end
      end
    end

    if (cmd_i.erase && col_q != '0) begin
      col_d = col_m1;
      we_d  = cur_ok;
    end

    if (cmd_i.direct_wr) begin
      we_d = item_ok;
      wa_d = item_addr;
      wd_d = {item_q.cell_color, item_q.char_code};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q   <= ROW_W'(1);
      col_q   <= '0;
      pend_q  <= 1'b0;
      color_q <= tccw_pkg::RESET_COLOR;
      rep_q   <= '0;
      cnt_q   <= '0;
      we_q    <= 1'b0;
    end else begin
      row_q  <= row_d;
      col_q  <= col_d;
      pend_q <= pend_d;
      rep_q  <= rep_d;
      cnt_q  <= cnt_d;
      we_q   <= we_d;
      if (cfg_we_i) color_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q  <= item_d;
    wa_q    <= wa_d;
    wd_q    <= wd_d;
    wcopy_q <= wcopy_d;
    if (cmd_i.load_out) begin
      out_q.cursor_pos <= tccw_pkg::CURSOR_POS_W'(pos);
      out_q.cell_data  <= (tccw_pkg::func_e'(item_q.func) == tccw_pkg::FUNC_READ && item_ok) ?
                          rd_q : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_q) mem[wa_q] <= wcopy_q ? rd_q : wd_q;
    if (re) rd_q <= mem[ra[ADDR_W-1:0]];
  end

  assign sts_o.func     = tccw_pkg::func_e'(item_q.func);
  assign sts_o.pend     = pend_q;
  assign sts_o.cnt_last = cnt_last;
  assign sts_o.rep_last = rep_q == '0;

  assign out_data_o = out_q;

endmodule

// ===== src/text_console_cell_writer_core.sv =====
// Top level of the text console cell writer
//
// A text screen of COLUMNS x ROWS 16-bit cells (attribute high byte, character
// low byte) with a cursor that starts on row 1; row 0 is kept for the host.
// The input channel (in_valid_i / in_ready_o / in_data_i) takes one word per
// operation: put character, erase back, write cell at position, read cell.
// The output channel (out_valid_o / out_ready_i / out_data_o) returns one word
// per operation with the cursor position and, for a read, the cell contents.
// cfg_we_i / cfg_wdata_i set the text colour; write it only while idle.
// One operation at a time: a word is taken, executed, and its result is held
// in the output register until taken; the next word is taken after that.
// A tab is written as four space cells. A pending scroll is carried out through
// the memory's separate read and write ports, one cell per cycle, from row 1
// to the bottom row. After reset the screen memory is cleared one cell per
// cycle, with in_ready_o low; config writes are still taken.
// A stalled receiver holds the result and blocks new input.
module text_console_cell_writer_core #(
  parameter int COLUMNS = tccw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tccw_pkg::DEF_ROWS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  tccw_pkg::in_t                in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output tccw_pkg::out_t               out_data_o,
  input  logic                         cfg_we_i,
  input  logic [tccw_pkg::COLOR_W-1:0] cfg_wdata_i
);

  tccw_pkg::cmd_t cmd;
  tccw_pkg::sts_t sts;

  tccw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tccw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== src/tccw_checker.sv =====
// Port-level checks for the text console cell writer, bound to the top level
module tccw_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input tccw_pkg::out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("result word dropped or changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input taken while a result is outstanding");

  a_out_then_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i) |=> (in_ready_o && !out_valid_o))
    else $error("not ready for the next word after a result was taken");

  a_in_then_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (!in_ready_o && !out_valid_o))
    else $error("result or ready too early after an input word");

endmodule

bind text_console_cell_writer_core tccw_checker u_tccw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
